FILE: src/lirs_pkg.sv
package lirs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 20;
    localparam int PHASE_W  = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = 21'h01_0000;
    localparam logic [STEP_W-1:0]  MIN_STEP   = 20'd1024;
    localparam logic [STEP_W-1:0]  STEP_RESET = 20'h1_0000;

    localparam int CMD_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP     = 2'd0,
        CFG_LOWPASS_ENABLE = 2'd1,
        CFG_BYPASS_MODE    = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_back_state;

    // classified item handed from front to back
    typedef struct packed {
        logic                bypass;
        logic [SAMPLE_W-1:0] value;
        logic                blk;
    } t_cmd;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                run_last;
        logic                blk;
    } t_res;

endpackage

FILE: src/lirs_fifo.sv
module lirs_fifo
    import lirs_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: src/lirs_front.sv
module lirs_front
    import lirs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_blk,
    input  logic                i_bypass,
    input  logic                i_lowpass,
    output t_cmd                o_cmd
);

    logic [SAMPLE_W-1:0] r_older_tap, n_older_tap;
    logic [SAMPLE_W-1:0] r_newer_tap, n_newer_tap;
    logic [SAMPLE_W+1:0] sum;
    logic [SAMPLE_W+1:0] sum_adj;
    logic [SAMPLE_W-1:0] filtered;

    // 1-2-1 sum, then divide by four rounding toward zero
    assign sum = {{2{r_older_tap[SAMPLE_W-1]}}, r_older_tap}
               + {r_newer_tap[SAMPLE_W-1], r_newer_tap, 1'b0}
               + {{2{i_sample[SAMPLE_W-1]}}, i_sample};
    assign sum_adj  = sum + (sum[SAMPLE_W+1] ? (SAMPLE_W+2)'(3) : '0);
    assign filtered = sum_adj[SAMPLE_W+1:2];

    always_comb begin
        o_cmd.bypass = i_bypass;
        o_cmd.blk    = i_blk;
        o_cmd.value  = (!i_bypass && i_lowpass) ? filtered : i_sample;
        n_older_tap  = r_older_tap;
        n_newer_tap  = r_newer_tap;
        // taps hold unless the prefilter is in use
        if (i_accept && !i_bypass && i_lowpass) begin
            n_older_tap = r_newer_tap;
            n_newer_tap = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older_tap <= '0;
            r_newer_tap <= '0;
        end else begin
            r_older_tap <= n_older_tap;
            r_newer_tap <= n_newer_tap;
        end
    end

endmodule

FILE: src/lirs_back.sv
module lirs_back
    import lirs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic [STEP_W-1:0] i_step,
    output t_res              o_res,
    output logic              o_push,
    input  logic              i_out_full
);

    t_back_state r_state, n_state;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [SAMPLE_W-1:0] r_prev, n_prev;
    logic [SAMPLE_W-1:0] r_cur, n_cur;
    logic                r_blk, n_blk;

    logic signed [SAMPLE_W:0]     delta;
    logic signed [SAMPLE_W:0]     frac;
    logic signed [2*SAMPLE_W+1:0] prod;
    logic [SAMPLE_W:0]            offs;
    logic [SAMPLE_W:0]            y_wide;
    logic [PHASE_W-1:0]           phase_adv;
    logic                         adv_last;
    logic                         phase_whole;

    assign delta  = $signed({r_cur[SAMPLE_W-1], r_cur}) - $signed({r_prev[SAMPLE_W-1], r_prev});
    assign frac   = $signed({1'b0, r_phase[SAMPLE_W-1:0]});
    assign prod   = delta * frac;
    // arithmetic shift by 16 floors; the offset never exceeds delta in size
    assign offs   = prod[2*SAMPLE_W:SAMPLE_W];
    assign y_wide = {r_prev[SAMPLE_W-1], r_prev} + offs;

    assign phase_adv   = r_phase + {1'b0, i_step};
    assign adv_last    = (phase_adv >= PHASE_ONE);
    assign phase_whole = (r_phase >= PHASE_ONE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && !i_cmd.bypass && !phase_whole) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_out_full && adv_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        o_push    = 1'b0;
        o_res     = '{sample: y_wide[SAMPLE_W-1:0], run_last: adv_last,
                      blk: adv_last && r_blk};
        n_phase   = r_phase;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_blk     = r_blk;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.bypass) begin
                        o_res = '{sample: i_cmd.value, run_last: 1'b1, blk: i_cmd.blk};
                        if (!i_out_full) begin
                            o_push    = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_cur     = i_cmd.value;
                        n_blk     = i_cmd.blk;
                        // empty run: drop one whole step of phase, no item out
                        if (phase_whole) begin
                            n_phase = r_phase - PHASE_ONE;
                            n_prev  = i_cmd.value;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (!i_out_full) begin
                    o_push  = 1'b1;
                    n_phase = adv_last ? phase_adv - PHASE_ONE : phase_adv;
                    if (adv_last) begin
                        n_prev = r_cur;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_blk <= n_blk;
    end

    a_run_phase_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_phase < PHASE_ONE)
        else $error("phase reached one inside a run");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_out_full)
        else $error("result pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> !i_cmd_empty)
        else $error("command popped from an empty queue");

    a_run_end_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && o_push && adv_last) |=> (r_state == ST_IDLE && r_prev == $past(r_cur)))
        else $error("run end did not advance previous value");

endmodule

FILE: src/linear_interp_pcm_resampler.sv
// Linear-interpolation PCM resampler.
// Input side is a queue write port: present i_sample_in and i_block_end with
// push; the item is taken on a clock edge where push is high and full is low.
// Results leave through a queue read port: while empty is low the oldest
// result sits on o_sample_out, o_run_last and o_block_end_out; pop takes it.
// Configuration (phase step, prefilter enable, bypass) is written through
// i_cfg_we / i_cfg_addr / i_cfg_wdata and should change only while idle.
// A taken item is registered in the command queue; the back end takes it
// from there into its run state, from which its first result is written to
// the result queue; a bypassed item goes straight on to the result queue.
// Throughput: the back end emits one result per cycle while the result
// queue has room; an item that yields N results occupies it for those
// results plus taking it from the command queue (only that when it yields
// none or when bypassed), so up to 64 results at the smallest step. The
// interpolation unit in the back end is the bottleneck.
// When the receiver stalls, the result queue fills, the back end holds, the
// command queue fills and full rises; nothing is dropped.
// Reset clears both queues, the prefilter taps, phase and previous value,
// and loads phase step 1.0, prefilter off, bypass on.
module linear_interp_pcm_resampler
    import lirs_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [SAMPLE_W-1:0]  i_sample_in,
    input  logic                 i_block_end,
    output logic                 empty,
    input  logic                 pop,
    output logic [SAMPLE_W-1:0]  o_sample_out,
    output logic                 o_run_last,
    output logic                 o_block_end_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [STEP_W-1:0]    i_cfg_wdata
);

    logic [STEP_W-1:0] r_phase_step;
    logic              r_lowpass_enable;
    logic              r_bypass_mode;
    logic [STEP_W-1:0] step;

    logic accept;
    t_cmd front_cmd;
    t_cmd back_cmd;
    logic cmd_empty;
    logic cmd_pop;
    t_res back_res;
    t_res out_res;
    logic res_push;
    logic res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step     <= STEP_RESET;
            r_lowpass_enable <= 1'b0;
            r_bypass_mode    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PHASE_STEP:     r_phase_step     <= i_cfg_wdata;
                CFG_LOWPASS_ENABLE: r_lowpass_enable <= i_cfg_wdata[0];
                CFG_BYPASS_MODE:    r_bypass_mode    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clamp small steps so a run never exceeds 64 results
    assign step   = (r_phase_step < MIN_STEP) ? MIN_STEP : r_phase_step;
    assign accept = push && !full;

    lirs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_sample  (i_sample_in),
        .i_blk     (i_block_end),
        .i_bypass  (r_bypass_mode),
        .i_lowpass (r_lowpass_enable),
        .o_cmd     (front_cmd)
    );

    lirs_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    lirs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_step      (step),
        .o_res       (back_res),
        .o_push      (res_push),
        .i_out_full  (res_full)
    );

    lirs_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_sample_out    = out_res.sample;
    assign o_run_last      = out_res.run_last;
    assign o_block_end_out = out_res.blk;

endmodule
